@@ hw/rtl/flag_cube_dilation_top_defines.svh @@
// Assertion macros for the flag cube dilation block.
// Used by flag_cube_dilation_top.sv; expects i_clk and i_rst_n in scope.
`ifndef FLAG_CUBE_DILATION_TOP_DEFINES_SVH
`define FLAG_CUBE_DILATION_TOP_DEFINES_SVH

// Check an implication in the same cycle.
`define FCD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("flag_cube_dilation: implication check failed");

// Check an implication in the next cycle.
`define FCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("flag_cube_dilation: next-cycle check failed");

`endif

@@ hw/rtl/fcd_pkg.sv @@
// Shared constants and types for the flag cube dilation block.
// No dependencies; used by the channel interfaces and the top level.
package fcd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNELS_IN_USE = 3'd0,
        CFG_POLS_IN_USE     = 3'd1,
        CFG_EXTEND_POLS     = 3'd2,
        CFG_NEAR_TIME       = 3'd3,
        CFG_NEAR_FREQ       = 3'd4,
        CFG_GROW_AROUND     = 3'd5
    } t_cfg_reg;

    localparam logic [1:0] ROWS_NONE = 2'd0;
    localparam logic [1:0] ROWS_ONE  = 2'd1;
    localparam logic [1:0] ROWS_FULL = 2'd2;

    localparam logic [3:0] AROUND_LIMIT = 4'd4;

    localparam int WIN_COLS = 3;
    localparam int WIN_ROWS = 3;

endpackage

@@ hw/rtl/fcd_channel_ifs.sv @@
// Valid/ready channel interfaces for the flag cube dilation block.
// Depends on fcd_pkg for the configuration index and data widths.
interface fcd_in_if #(
    parameter int POLS = 4
);
    logic            valid;
    logic            ready;
    logic [POLS-1:0] pol_flags;
    logic            is_padding;
    logic            frame_start;

    modport source (output valid, output pol_flags, output is_padding,
                    output frame_start, input ready);
    modport sink   (input valid, input pol_flags, input is_padding,
                    input frame_start, output ready);
endinterface

interface fcd_out_if #(
    parameter int POLS = 4,
    parameter int CH_W = 10
);
    logic            valid;
    logic            ready;
    logic [POLS-1:0] final_flags;
    logic [POLS-1:0] grown_flags;
    logic [CH_W-1:0] out_channel;

    modport source (output valid, output final_flags, output grown_flags,
                    output out_channel, input ready);
    modport sink   (input valid, input final_flags, input grown_flags,
                    input out_channel, output ready);
endinterface

interface fcd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [fcd_pkg::CFG_IDX_W-1:0]   index;
    logic [fcd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/flag_cube_dilation_top.sv @@
// Top level of the flag cube dilation block: line buffer memory, 3x3 window, grow logic.
// Depends on fcd_pkg, fcd_channel_ifs.sv and flag_cube_dilation_top_defines.svh.
//
// Takes one raster cell per cycle and gives one result per cycle at most while the output
// is not stalled; the rate is set by the single line buffer memory, read at accept and
// written back when the cell leaves stage 1, with write data forwarded when the same
// channel is read back to back (one channel in use). The cell emitted is the one a row
// plus one cell behind the input, registered when the beat that completes its window
// leaves stage 1, so a frame drains with channels_in_use + 1 padding beats. Reads of line
// buffer entries that the current frame has not yet written are masked by the row count.
// Configuration writes are always ready and apply at once; write them only while idle.
`include "flag_cube_dilation_top_defines.svh"

module flag_cube_dilation_top #(
    parameter int MAX_CHANNELS = 1024,
    parameter int POLS         = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fcd_in_if.sink      i_in,
    fcd_out_if.source   o_out,
    fcd_cfg_if.sink     i_cfg
);

    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
    localparam int PCNT_W = $clog2(POLS + 1);
    localparam int CELL_W = POLS + 1;
    localparam int ENT_W  = 2 * CELL_W;

    localparam logic [CNT_W-1:0]  NCH_MAX = CNT_W'(MAX_CHANNELS);
    localparam logic [PCNT_W-1:0] NP_MAX  = PCNT_W'(POLS);

    // configuration
    logic [CNT_W-1:0]  r_nch_cfg;
    logic [PCNT_W-1:0] r_np_cfg;
    logic              r_extend_pols;
    logic              r_near_time;
    logic              r_near_freq;
    logic              r_grow_around;

    // stream control
    logic [CH_W-1:0] r_chan;
    logic [1:0]      r_rows;

    // stage 1: memory data pending
    logic              r_s1_valid;
    logic [CH_W-1:0]   r_s1_c;
    logic [CH_W-1:0]   r_s1_cc;
    logic [CELL_W-1:0] r_s1_cell;
    logic              r_s1_gate_a;
    logic              r_s1_gate_b;
    logic              r_s1_fs;
    logic              r_s1_left_ok;
    logic              r_s1_right_ok;
    logic              r_fwd;
    logic [ENT_W-1:0]  r_fwd_data;
    logic [ENT_W-1:0]  r_rdata;

    logic [ENT_W-1:0]  mem [MAX_CHANNELS];

    logic [CELL_W-1:0] r_win [fcd_pkg::WIN_COLS][fcd_pkg::WIN_ROWS];
    logic [CELL_W-1:0] n_win [fcd_pkg::WIN_COLS][fcd_pkg::WIN_ROWS];

    // output register
    logic              r_out_valid;
    logic [POLS-1:0]   r_out_final;
    logic [POLS-1:0]   r_out_grown;
    logic [CH_W-1:0]   r_out_ch;

    logic [CNT_W-1:0]  nch;
    logic [PCNT_W-1:0] np;
    logic [POLS-1:0]   pmask;
    logic              s1_fire;
    logic              in_ready;
    logic              in_accept;

    logic [CH_W-1:0]   s0_c;
    logic [CH_W-1:0]   s0_cc;
    logic [1:0]        s0_rows;
    logic [CH_W-1:0]   n_chan;
    logic [1:0]        n_rows;
    logic              s0_gate_a;
    logic              s0_gate_b;
    logic [CELL_W-1:0] s0_cell;

    logic [ENT_W-1:0]  s1_rd;
    logic [ENT_W-1:0]  s1_wdata;
    logic              emit;
    logic [POLS-1:0]   ctr;
    logic [POLS-1:0]   grow;

    always_comb begin
        if (r_nch_cfg == '0) begin
            nch = CNT_W'(1);
        end else if (r_nch_cfg > NCH_MAX) begin
            nch = NCH_MAX;
        end else begin
            nch = r_nch_cfg;
        end
        if (r_np_cfg == '0) begin
            np = PCNT_W'(1);
        end else if (r_np_cfg > NP_MAX) begin
            np = NP_MAX;
        end else begin
            np = r_np_cfg;
        end
        for (int k = 0; k < POLS; k++) begin
            pmask[k] = (int'(np) > k);
        end
    end

    assign s1_fire   = r_s1_valid && (!r_out_valid || o_out.ready);
    assign in_ready  = !r_s1_valid || s1_fire;
    assign in_accept = i_in.valid && in_ready;
    assign i_in.ready = in_ready;
    assign i_cfg.ready = 1'b1;

    // stage 0: channel and row counting
    always_comb begin
        logic [CH_W-1:0] cnt0;
        logic [1:0]      rows0;
        logic            wrap;
        logic            row_end;
        cnt0  = i_in.frame_start ? '0 : r_chan;
        rows0 = i_in.frame_start ? fcd_pkg::ROWS_NONE : r_rows;
        wrap  = (CNT_W'(cnt0) >= nch);
        s0_c  = wrap ? '0 : cnt0;
        s0_rows = (wrap && rows0 != fcd_pkg::ROWS_FULL) ? rows0 + 2'd1 : rows0;
        s0_gate_a = (s0_rows == fcd_pkg::ROWS_FULL);
        s0_gate_b = (s0_rows != fcd_pkg::ROWS_NONE);
        row_end = ((CNT_W'(s0_c) + CNT_W'(1)) >= nch);
        n_chan  = row_end ? '0 : s0_c + CH_W'(1);
        n_rows  = (row_end && s0_rows != fcd_pkg::ROWS_FULL) ? s0_rows + 2'd1 : s0_rows;
        s0_cc   = (s0_c == '0) ? CH_W'(nch - CNT_W'(1)) : s0_c - CH_W'(1);
        s0_cell = i_in.is_padding ? '0 : {1'b1, i_in.pol_flags & pmask};
    end

    // stage 1: window shift and grow logic
    always_comb begin
        logic [CELL_W-1:0] a_cell;
        logic [CELL_W-1:0] b_cell;
        logic [POLS-1:0]   m [fcd_pkg::WIN_COLS][fcd_pkg::WIN_ROWS];
        logic [8:0]        votes;
        logic [3:0]        cnt;
        s1_rd    = r_fwd ? r_fwd_data : r_rdata;
        a_cell   = r_s1_gate_a ? s1_rd[ENT_W-1:CELL_W] : '0;
        b_cell   = r_s1_gate_b ? s1_rd[CELL_W-1:0] : '0;
        s1_wdata = {s1_rd[CELL_W-1:0], r_s1_cell};
        for (int r = 0; r < fcd_pkg::WIN_ROWS; r++) begin
            n_win[0][r] = r_s1_fs ? '0 : r_win[1][r];
            n_win[1][r] = r_s1_fs ? '0 : r_win[2][r];
        end
        n_win[2][0] = a_cell;
        n_win[2][1] = b_cell;
        n_win[2][2] = r_s1_cell;
        for (int cl = 0; cl < fcd_pkg::WIN_COLS; cl++) begin
            for (int r = 0; r < fcd_pkg::WIN_ROWS; r++) begin
                if (n_win[cl][r][POLS] && (cl != 0 || r_s1_left_ok)
                        && (cl != 2 || r_s1_right_ok)) begin
                    m[cl][r] = n_win[cl][r][POLS-1:0] & pmask;
                end else begin
                    m[cl][r] = '0;
                end
            end
        end
        emit = n_win[1][1][POLS];
        ctr  = m[1][1];
        grow = '0;
        if (r_near_time) begin
            grow = grow | m[1][0] | m[1][2];
        end
        if (r_near_freq) begin
            grow = grow | m[0][1] | m[2][1];
        end
        if (r_extend_pols && ctr != '0) begin
            grow = grow | pmask;
        end
        for (int k = 0; k < POLS; k++) begin
            for (int cl = 0; cl < fcd_pkg::WIN_COLS; cl++) begin
                for (int r = 0; r < fcd_pkg::WIN_ROWS; r++) begin
                    votes[cl * fcd_pkg::WIN_ROWS + r] = m[cl][r][k];
                end
            end
            cnt = 4'($countones(votes));
            if (r_grow_around && !ctr[k] && cnt > fcd_pkg::AROUND_LIMIT) begin
                grow[k] = 1'b1;
            end
        end
        grow = grow & pmask;
    end

    // line buffer memory: entry holds {older row cell, newer row cell}
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rdata <= mem[s0_c];
        end
        if (s1_fire) begin
            mem[r_s1_c] <= s1_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nch_cfg     <= CNT_W'(1024);
            r_np_cfg      <= PCNT_W'(4);
            r_extend_pols <= 1'b0;
            r_near_time   <= 1'b0;
            r_near_freq   <= 1'b0;
            r_grow_around <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                fcd_pkg::CFG_CHANNELS_IN_USE: r_nch_cfg     <= i_cfg.data[CNT_W-1:0];
                fcd_pkg::CFG_POLS_IN_USE:     r_np_cfg      <= i_cfg.data[PCNT_W-1:0];
                fcd_pkg::CFG_EXTEND_POLS:     r_extend_pols <= i_cfg.data[0];
                fcd_pkg::CFG_NEAR_TIME:       r_near_time   <= i_cfg.data[0];
                fcd_pkg::CFG_NEAR_FREQ:       r_near_freq   <= i_cfg.data[0];
                fcd_pkg::CFG_GROW_AROUND:     r_grow_around <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan      <= '0;
            r_rows      <= fcd_pkg::ROWS_NONE;
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int cl = 0; cl < fcd_pkg::WIN_COLS; cl++) begin
                for (int r = 0; r < fcd_pkg::WIN_ROWS; r++) begin
                    r_win[cl][r] <= '0;
                end
            end
        end else begin
            if (in_accept) begin
                r_chan <= n_chan;
                r_rows <= n_rows;
                r_fwd  <= s1_fire && (r_s1_c == s0_c);
            end
            if (in_ready) begin
                r_s1_valid <= in_accept;
            end
            if (s1_fire) begin
                r_win       <= n_win;
                r_out_valid <= emit;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_c        <= s0_c;
            r_s1_cc       <= s0_cc;
            r_s1_cell     <= s0_cell;
            r_s1_gate_a   <= s0_gate_a;
            r_s1_gate_b   <= s0_gate_b;
            r_s1_fs       <= i_in.frame_start;
            r_s1_left_ok  <= (s0_cc != '0);
            r_s1_right_ok <= (s0_c != '0);
            r_fwd_data    <= s1_wdata;
        end
        if (s1_fire) begin
            r_out_final <= ctr | grow;
            r_out_grown <= grow;
            r_out_ch    <= r_s1_cc;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.final_flags = r_out_final;
    assign o_out.grown_flags = r_out_grown;
    assign o_out.out_channel = r_out_ch;

    `FCD_ASSERT_IMPL(a_rows_saturate, 1'b1, r_rows <= fcd_pkg::ROWS_FULL)
    `FCD_ASSERT_NEXT(a_out_hold, r_out_valid && !o_out.ready, r_out_valid)
    `FCD_ASSERT_IMPL(a_fwd_same_entry, r_fwd, r_s1_c == $past(r_s1_c))
    `FCD_ASSERT_IMPL(a_out_from_fire, $rose(r_out_valid), $past(s1_fire))

endmodule
